@@ rtl/kcl_pkg.sv @@
// shared types, codes and constants of the keypad code lock controller
package kcl_pkg;

    localparam int CODE_LEN_DEF = 8;

    localparam int KEY_W    = 8;
    localparam int STATUS_W = 4;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int FAIL_W   = 4;
    localparam int CHECK_W  = 8;
    localparam int RESULT_W = STATUS_W + MODE_W + COUNT_W + FAIL_W + CHECK_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [KEY_W-1:0] KEY_DIGIT_LO = 8'h30;
    localparam logic [KEY_W-1:0] KEY_DIGIT_HI = 8'h39;
    localparam logic [KEY_W-1:0] KEY_RETURN   = 8'h0D;
    localparam logic [KEY_W-1:0] KEY_ESC      = 8'h1B;

    localparam logic [FAIL_W-1:0] FAIL_LIMIT_RESET = 4'd5;
    localparam logic [FAIL_W-1:0] FAIL_MAX         = 4'd15;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED  = 4'd0,
        ST_DIGIT    = 4'd1,
        ST_TOO_LONG = 4'd2,
        ST_UNLOCKED = 4'd3,
        ST_WRONG    = 4'd4,
        ST_LOCKOUT  = 4'd5,
        ST_FIRST    = 4'd6,
        ST_SAVED    = 4'd7,
        ST_MISMATCH = 4'd8,
        ST_RESET    = 4'd9,
        ST_ALARM    = 4'd10,
        ST_CLEARED  = 4'd11
    } status_t;

    // external mode codes
    localparam logic [MODE_W-1:0] MODE_CODE_LOCKED   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_SET      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_CONFIRM  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_UNLOCKED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CODE_LOCKOUT  = 3'd4;

    // lock state machine, one-hot
    typedef enum logic [4:0] {
        MODE_LOCKED   = 5'b00001,
        MODE_SET      = 5'b00010,
        MODE_CONFIRM  = 5'b00100,
        MODE_UNLOCKED = 5'b01000,
        MODE_LOCKOUT  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [CHECK_W-1:0]  check_byte;
        logic [FAIL_W-1:0]   failures;
        logic [COUNT_W-1:0]  digit_count;
        logic [MODE_W-1:0]   mode;
        status_t             status;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] c;
        begin
            case (m)
                MODE_LOCKED:   c = MODE_CODE_LOCKED;
                MODE_SET:      c = MODE_CODE_SET;
                MODE_CONFIRM:  c = MODE_CODE_CONFIRM;
                MODE_UNLOCKED: c = MODE_CODE_UNLOCKED;
                MODE_LOCKOUT:  c = MODE_CODE_LOCKOUT;
                default:       c = MODE_CODE_SET;
            endcase
            return c;
        end
    endfunction

endpackage

@@ rtl/kcl_engine.sv @@
// lock state, code buffers and per-key decision logic
module kcl_engine #(
    parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [kcl_pkg::KEY_W-1:0]   key,
    input  logic [kcl_pkg::FAIL_W-1:0]  fail_limit,
    output kcl_pkg::result_t            result
);

    localparam logic [kcl_pkg::COUNT_W-1:0] LEN = kcl_pkg::COUNT_W'(CODE_LEN);

    kcl_pkg::mode_t                mode_reg, mode_next;
    logic [kcl_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [kcl_pkg::FAIL_W-1:0]    fail_reg, fail_next;
    logic [7:0] entry_reg  [CODE_LEN];
    logic [7:0] entry_next [CODE_LEN];
    logic [7:0] first_reg  [CODE_LEN];
    logic [7:0] first_next [CODE_LEN];
    logic [7:0] code_reg   [CODE_LEN];
    logic [7:0] code_next  [CODE_LEN];

    logic                          is_digit;
    logic                          entry_eq_code;
    logic                          first_eq_entry;
    logic [7:0]                    first_sum;
    logic [kcl_pkg::FAIL_W-1:0]    fail_inc;
    kcl_pkg::status_t              status;
    logic [kcl_pkg::CHECK_W-1:0]   check;

    assign is_digit = (key >= kcl_pkg::KEY_DIGIT_LO) && (key <= kcl_pkg::KEY_DIGIT_HI);
    assign fail_inc = (fail_reg < kcl_pkg::FAIL_MAX) ? fail_reg + 1'b1 : fail_reg;

    always_comb begin
        entry_eq_code  = 1'b1;
        first_eq_entry = 1'b1;
        first_sum      = 8'd0;
        for (int i = 0; i < CODE_LEN; i++) begin
            if (entry_reg[i] != code_reg[i]) entry_eq_code = 1'b0;
            if (first_reg[i] != entry_reg[i]) first_eq_entry = 1'b0;
            first_sum = first_sum + first_reg[i];
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        fail_next  = fail_reg;
        entry_next = entry_reg;
        first_next = first_reg;
        code_next  = code_reg;
        status     = kcl_pkg::ST_IGNORED;
        check      = '0;

        if (is_digit) begin
            if (mode_reg == kcl_pkg::MODE_LOCKED || mode_reg == kcl_pkg::MODE_SET ||
                mode_reg == kcl_pkg::MODE_CONFIRM) begin
                if (count_reg < LEN) begin
                    for (int i = 0; i < CODE_LEN; i++) begin
                        if (count_reg == kcl_pkg::COUNT_W'(i)) entry_next[i] = key;
                    end
                    count_next = count_reg + 1'b1;
                    status     = kcl_pkg::ST_DIGIT;
                end else begin
                    for (int i = 0; i < CODE_LEN; i++) entry_next[i] = 8'd0;
                    count_next = '0;
                    status     = kcl_pkg::ST_TOO_LONG;
                end
            end
        end else if (key == kcl_pkg::KEY_RETURN) begin
            case (mode_reg)
                kcl_pkg::MODE_LOCKED: begin
                    if (entry_eq_code) begin
                        mode_next = kcl_pkg::MODE_UNLOCKED;
                        status    = kcl_pkg::ST_UNLOCKED;
                    end else if (fail_inc > fail_limit) begin
                        mode_next = kcl_pkg::MODE_LOCKOUT;
                        fail_next = '0;
                        status    = kcl_pkg::ST_LOCKOUT;
                    end else begin
                        fail_next = fail_inc;
                        status    = kcl_pkg::ST_WRONG;
                    end
                    for (int i = 0; i < CODE_LEN; i++) entry_next[i] = 8'd0;
                    count_next = '0;
                end
                kcl_pkg::MODE_SET: begin
                    first_next = entry_reg;
                    for (int i = 0; i < CODE_LEN; i++) entry_next[i] = 8'd0;
                    count_next = '0;
                    mode_next  = kcl_pkg::MODE_CONFIRM;
                    status     = kcl_pkg::ST_FIRST;
                end
                kcl_pkg::MODE_CONFIRM: begin
                    if (first_eq_entry) begin
                        code_next = first_reg;
                        check     = ~first_sum;
                        mode_next = kcl_pkg::MODE_LOCKED;
                        status    = kcl_pkg::ST_SAVED;
                    end else begin
                        mode_next = kcl_pkg::MODE_SET;
                        status    = kcl_pkg::ST_MISMATCH;
                    end
                    for (int i = 0; i < CODE_LEN; i++) begin
                        first_next[i] = 8'd0;
                        entry_next[i] = 8'd0;
                    end
                    count_next = '0;
                end
                kcl_pkg::MODE_UNLOCKED: begin
                    for (int i = 0; i < CODE_LEN; i++) entry_next[i] = 8'd0;
                    count_next = '0;
                    mode_next  = kcl_pkg::MODE_SET;
                    status     = kcl_pkg::ST_RESET;
                end
                kcl_pkg::MODE_LOCKOUT: begin
                    mode_next = kcl_pkg::MODE_UNLOCKED;
                    status    = kcl_pkg::ST_ALARM;
                end
                default: begin
                    status = kcl_pkg::ST_IGNORED;
                end
            endcase
        end else if (key == kcl_pkg::KEY_ESC) begin
            for (int i = 0; i < CODE_LEN; i++) entry_next[i] = 8'd0;
            count_next = '0;
            status     = kcl_pkg::ST_CLEARED;
        end
    end

    assign result.status      = status;
    assign result.mode        = kcl_pkg::mode_code(mode_next);
    assign result.digit_count = count_next;
    assign result.failures    = fail_next;
    assign result.check_byte  = check;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= kcl_pkg::MODE_SET;
            count_reg <= '0;
            fail_reg  <= '0;
            for (int i = 0; i < CODE_LEN; i++) begin
                entry_reg[i] <= 8'd0;
                first_reg[i] <= 8'd0;
                code_reg[i]  <= 8'd0;
            end
        end else if (step_en) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
            entry_reg <= entry_next;
            first_reg <= first_next;
            code_reg  <= code_next;
        end
    end

endmodule

@@ rtl/keypad_code_lock_controller_top.sv @@
// top level of the keypad code lock controller: stream ports, apb register, result register
// Each key code beat yields exactly one result beat. A key is captured in an input
// register, decided by one pass of logic in the lock engine, and its result is loaded into
// the output register as the key advances; a new key is taken every cycle while the result
// side keeps up, and the engine state (mode, counts, code buffers) is updated at the same
// edge that loads the output register. Digits 0x30-0x39 fill the entry buffer in locked,
// set or confirm mode, enter (0x0D) drives the lock modes, escape (0x1B) clears the buffer,
// any other code is reported as ignored. The register fail_limit (byte address 0, reset 5)
// sets how many wrong codes are tolerated before lockout; write it only while no key is in
// flight. After reset the lock sits in set code mode with an all-zero stored code.
module keypad_code_lock_controller_top #(
    parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // key input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kcl_pkg::KEY_W-1:0]        s_tdata,   // [7:0] key_code
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] status, [6:4] mode, [11:7] digit_count, [15:12] failures,
    // [23:16] check_byte
    output logic [kcl_pkg::M_TDATA_W-1:0]    m_tdata,
    // apb register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // configuration register
    logic [kcl_pkg::FAIL_W-1:0] fail_limit_reg;
    logic                       fail_limit_sel;

    assign pready         = 1'b1;
    assign fail_limit_sel = (paddr[2] == 1'b0);
    assign prdata         = fail_limit_sel ? {28'd0, fail_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_limit_reg <= kcl_pkg::FAIL_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && fail_limit_sel) begin
            fail_limit_reg <= pwdata[kcl_pkg::FAIL_W-1:0];
        end
    end

    // input register
    logic                      in_valid_reg;
    logic [kcl_pkg::KEY_W-1:0] in_key_reg;
    logic                      advance;    // key in input register moves to result register

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg <= s_tdata;
        end
    end

    // lock engine, state commits on advance
    kcl_pkg::result_t step_result;

    kcl_engine #(
        .CODE_LEN (CODE_LEN)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .key        (in_key_reg),
        .fail_limit (fail_limit_reg),
        .result     (step_result)
    );

    // result register
    logic                           out_valid_reg;
    logic [kcl_pkg::RESULT_W-1:0]   out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = kcl_pkg::M_TDATA_W'(out_data_reg);

endmodule

@@ verif/keypad_code_lock_controller_top_tb.sv @@
// self-checking testbench of the keypad code lock top level: directed table, random sessions
module keypad_code_lock_controller_top_tb;
    import kcl_pkg::*;

    localparam int CODE_LEN = CODE_LEN_DEF;
    localparam logic [2:0] ADDR_FAIL_LIMIT = 3'd0;
    // key beats per random phase, four phases
    localparam int PHASE_KEYS = 355;
    // margin after the last pending result has come back
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_ROWS = 22;

    typedef logic [CODE_LEN-1:0][KEY_W-1:0] code_buf_t;

    // one line of the directed key table; the expected result is only used when typed is set
    typedef struct {
        logic [KEY_W-1:0]   key;
        int                 reps;
        bit                 typed;
        status_t            status;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        logic [FAIL_W-1:0]  fails;
        logic [CHECK_W-1:0] check;
    } key_row_t;

    // dut ports, every input known from time zero
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // lock model state, kept in step with every accepted key beat
    logic [MODE_W-1:0]    lock_mode_q;
    logic [COUNT_W-1:0]   entry_cnt_q;
    logic [FAIL_W-1:0]    fail_cnt_q;
    logic [FAIL_W-1:0]    fail_limit_q;
    code_buf_t            entry_buf_q;
    code_buf_t            first_buf_q;
    code_buf_t            stored_buf_q;

    result_t              pending_results[$];
    key_row_t             directed_rows [NUM_ROWS];

    int idle_pct = 0;
    int stall_pct = 0;
    int keys_sent = 0;
    int directed_keys = 0;
    int phase_keys = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int status_hits [16];

    keypad_code_lock_controller_top #(
        .CODE_LEN(CODE_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure, rate set per phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result beat %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_entry();
        entry_buf_q = '0;
        entry_cnt_q = '0;
    endfunction

    // next lock result for one key code; advances the lock model
    function automatic result_t predict_key(input logic [KEY_W-1:0] key);
        result_t            r;
        logic [CHECK_W-1:0] byte_sum;
        int                 i;
        r = '0;
        r.status = ST_IGNORED;
        if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
            // digits only count while a code is being typed
            if (lock_mode_q == MODE_CODE_LOCKED || lock_mode_q == MODE_CODE_SET
                    || lock_mode_q == MODE_CODE_CONFIRM) begin
                if (entry_cnt_q < CODE_LEN) begin
                    entry_buf_q[entry_cnt_q] = key;
                    entry_cnt_q++;
                    r.status = ST_DIGIT;
                end else begin
                    // overflow throws the whole entry away, digit not kept
                    clear_entry();
                    r.status = ST_TOO_LONG;
                end
            end
        end else if (key == KEY_RETURN) begin
            case (lock_mode_q)
                MODE_CODE_LOCKED: begin
                    if (entry_buf_q == stored_buf_q) begin
                        lock_mode_q = MODE_CODE_UNLOCKED;
                        r.status = ST_UNLOCKED;
                    end else begin
                        if (fail_cnt_q != FAIL_MAX) fail_cnt_q++;
                        if (fail_cnt_q > fail_limit_q) begin
                            lock_mode_q = MODE_CODE_LOCKOUT;
                            fail_cnt_q = '0;
                            r.status = ST_LOCKOUT;
                        end else begin
                            r.status = ST_WRONG;
                        end
                    end
                    clear_entry();
                end
                MODE_CODE_SET: begin
                    first_buf_q = entry_buf_q;
                    clear_entry();
                    lock_mode_q = MODE_CODE_CONFIRM;
                    r.status = ST_FIRST;
                end
                MODE_CODE_CONFIRM: begin
                    if (first_buf_q == entry_buf_q) begin
                        stored_buf_q = first_buf_q;
                        byte_sum = '0;
                        for (i = 0; i < CODE_LEN; i++) byte_sum += stored_buf_q[i];
                        r.check_byte = ~byte_sum;
                        lock_mode_q = MODE_CODE_LOCKED;
                        r.status = ST_SAVED;
                    end else begin
                        lock_mode_q = MODE_CODE_SET;
                        r.status = ST_MISMATCH;
                    end
                    first_buf_q = '0;
                    clear_entry();
                end
                MODE_CODE_UNLOCKED: begin
                    clear_entry();
                    lock_mode_q = MODE_CODE_SET;
                    r.status = ST_RESET;
                end
                MODE_CODE_LOCKOUT: begin
                    // entry buffer is left as it is
                    lock_mode_q = MODE_CODE_UNLOCKED;
                    r.status = ST_ALARM;
                end
                default: begin
                end
            endcase
        end else if (key == KEY_ESC) begin
            clear_entry();
            r.status = ST_CLEARED;
        end
        r.mode = lock_mode_q;
        r.digit_count = entry_cnt_q;
        r.failures = fail_cnt_q;
        status_hits[r.status]++;
        return r;
    endfunction

    // digits held in a zero-padded code buffer
    function automatic int code_length(input code_buf_t code);
        int n;
        n = 0;
        while (n < CODE_LEN && code[n] != '0) n++;
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] random_digit();
        return KEY_DIGIT_LO + KEY_W'($urandom_range(9));
    endfunction

    // one key beat; the expectation is queued at the edge that accepts it
    task automatic send_key(input logic [KEY_W-1:0] key, input bit typed,
                            input result_t typed_res);
        result_t predicted;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= key;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_key(key);
        pending_results.push_back(typed ? typed_res : predicted);
        keys_sent++;
        phase_keys++;
    endtask

    // a code followed by enter, with the odd stray key or escape mixed in;
    // lengths past the buffer run into the too-long path
    task automatic send_entry(input code_buf_t code, input int n);
        int i;
        int pick;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_key(KEY_W'($urandom_range(255)), 1'b0, '0);
            end else if (pick < 8) begin
                send_key(KEY_ESC, 1'b0, '0);
            end
            send_key((i < CODE_LEN) ? code[i] : random_digit(), 1'b0, '0);
        end
        send_key(KEY_RETURN, 1'b0, '0);
    endtask

    // one step of plausible keypad use, chosen from the current lock mode
    task automatic random_session();
        code_buf_t code;
        int        n;
        int        pick;
        int        i;
        pick = $urandom_range(99);
        for (i = 0; i < CODE_LEN; i++) code[i] = random_digit();
        n = $urandom_range(99);
        if (n < 5) n = 0;
        else if (n < 12) n = CODE_LEN + $urandom_range(1, 2);
        else n = $urandom_range(1, CODE_LEN);
        if (pick < 8) begin
            // plain noise, any key code at all
            repeat ($urandom_range(1, 4)) send_key(KEY_W'($urandom_range(255)), 1'b0, '0);
        end else begin
            case (lock_mode_q)
                MODE_CODE_SET: send_entry(code, n);
                MODE_CODE_CONFIRM: begin
                    if (pick < 75) send_entry(first_buf_q, code_length(first_buf_q));
                    else send_entry(code, n);
                end
                MODE_CODE_LOCKED: begin
                    if (pick < 60) send_entry(stored_buf_q, code_length(stored_buf_q));
                    else send_entry(code, n);
                end
                MODE_CODE_UNLOCKED: begin
                    if (pick < 70) send_key(KEY_RETURN, 1'b0, '0);
                    else if (pick < 85) send_key(code[0], 1'b0, '0);
                    else send_key(KEY_ESC, 1'b0, '0);
                end
                default: begin
                    if (pick < 65) send_key(KEY_RETURN, 1'b0, '0);
                    else if (pick < 82) send_key(code[0], 1'b0, '0);
                    else send_key(KEY_ESC, 1'b0, '0);
                end
            endcase
        end
    endtask

    // setup cycle then access cycle, then the bus goes idle; a read compares
    // against the model's limit
    task automatic apb_access(input bit is_write, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= ADDR_FAIL_LIMIT;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (is_write) begin
            fail_limit_q = value[FAIL_W-1:0];
        end else if (prdata !== {28'd0, fail_limit_q}) begin
            report_mismatch("fail_limit read back", prdata, {28'd0, fail_limit_q});
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and let every queued result come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // new limit while idle, then random sessions at the given idle and stall rates
    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input logic [31:0] limit_word);
        wait_drain();
        apb_access(1'b1, limit_word);
        apb_access(1'b0, '0);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        phase_keys = 0;
        while (phase_keys < PHASE_KEYS) random_session();
    endtask

    // compare every result beat with the oldest expectation, field by field
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_W-1:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", got, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.mode != want.mode)
                    report_mismatch("mode", got.mode, want.mode);
                if (got.digit_count != want.digit_count)
                    report_mismatch("digit_count", got.digit_count, want.digit_count);
                if (got.failures != want.failures)
                    report_mismatch("failures", got.failures, want.failures);
                if (got.check_byte != want.check_byte)
                    report_mismatch("check_byte", got.check_byte, want.check_byte);
            end
        end
    end

    // watchdog on total run length
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int      i;
        int      r;
        result_t typed_res;

        // directed keys run with fail_limit 0, so one wrong code locks out;
        // typed rows are the ones whose result is plain from the lock rules
        directed_rows = '{
            '{8'h00,      1, 1'b1, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{8'hFF,      1, 1'b1, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{8'h2F,      1, 1'b1, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{8'h3A,      1, 1'b1, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{8'h39,      8, 1'b1, ST_DIGIT,    MODE_CODE_SET,      8, 0, 8'h00},
            '{8'h30,      1, 1'b1, ST_TOO_LONG, MODE_CODE_SET,      0, 0, 8'h00},
            '{8'h34,      1, 1'b0, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{KEY_ESC,    1, 1'b1, ST_CLEARED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_FIRST,    MODE_CODE_CONFIRM,  0, 0, 8'h00},
            '{8'h31,      1, 1'b0, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_MISMATCH, MODE_CODE_SET,      0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_FIRST,    MODE_CODE_CONFIRM,  0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_SAVED,    MODE_CODE_LOCKED,   0, 0, 8'hFF},
            '{8'h32,      1, 1'b0, ST_IGNORED,  MODE_CODE_SET,      0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_LOCKOUT,  MODE_CODE_LOCKOUT,  0, 0, 8'h00},
            '{8'h36,      1, 1'b1, ST_IGNORED,  MODE_CODE_LOCKOUT,  0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_ALARM,    MODE_CODE_UNLOCKED, 0, 0, 8'h00},
            '{8'h35,      1, 1'b1, ST_IGNORED,  MODE_CODE_UNLOCKED, 0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_RESET,    MODE_CODE_SET,      0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_FIRST,    MODE_CODE_CONFIRM,  0, 0, 8'h00},
            '{KEY_RETURN, 1, 1'b1, ST_SAVED,    MODE_CODE_LOCKED,   0, 0, 8'hFF},
            '{KEY_RETURN, 1, 1'b1, ST_UNLOCKED, MODE_CODE_UNLOCKED, 0, 0, 8'h00}
        };

        // lock model after reset: set code mode, all buffers zero
        lock_mode_q = MODE_CODE_SET;
        entry_cnt_q = '0;
        fail_cnt_q = '0;
        fail_limit_q = FAIL_LIMIT_RESET;
        entry_buf_q = '0;
        first_buf_q = '0;
        stored_buf_q = '0;
        for (i = 0; i < 16; i++) status_hits[i] = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value first, then the low extreme for the directed part
        apb_access(1'b0, '0);
        apb_access(1'b1, 32'h0000_0000);
        apb_access(1'b0, '0);

        for (i = 0; i < NUM_ROWS; i++) begin
            for (r = 0; r < directed_rows[i].reps; r++) begin
                typed_res.status = directed_rows[i].status;
                typed_res.mode = directed_rows[i].mode;
                typed_res.digit_count = directed_rows[i].count;
                typed_res.failures = directed_rows[i].fails;
                typed_res.check_byte = directed_rows[i].check;
                send_key(directed_rows[i].key,
                         directed_rows[i].typed && r == directed_rows[i].reps - 1, typed_res);
            end
        end
        directed_keys = keys_sent;

        // limit 15 never locks out and lets the failure count saturate;
        // upper pwdata bits set on two of the writes must be dropped
        run_phase(0, 0, 32'h0000_000F);
        run_phase(60, 0, 32'hFFFF_FFF3);
        run_phase(0, 60, 32'h0000_0000);
        run_phase(21, 21, 32'h7FFF_FFF5);
        wait_drain();

        $display("covered %0d key beats (%0d directed) and %0d result beats, limits 0/3/5/15",
                 keys_sent, directed_keys, results_seen);
        $display("codes saved %0d, unlocks %0d, wrong %0d, lockouts %0d, alarms %0d, long %0d",
                 status_hits[ST_SAVED], status_hits[ST_UNLOCKED], status_hits[ST_WRONG],
                 status_hits[ST_LOCKOUT], status_hits[ST_ALARM], status_hits[ST_TOO_LONG]);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ keypad_code_lock_controller_top.f @@
rtl/kcl_pkg.sv
rtl/kcl_engine.sv
rtl/keypad_code_lock_controller_top.sv
verif/keypad_code_lock_controller_top_tb.sv
